// ===== design/mpwm_pkg.sv =====
// Shared types and constants for the multichannel PWM controller.
`timescale 1ns / 1ps
package mpwm_pkg;
    localparam int NumChannels = 4;
    localparam int ChW = 2;
    localparam int DataW = 32;
    localparam int DoneShift = 16;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic [2:0] SEL_CTRL   = 3'd0;
    localparam logic [2:0] SEL_PERIOD = 3'd1;
    localparam logic [2:0] SEL_DUTY   = 3'd2;
    localparam logic [2:0] SEL_CNT    = 3'd3;
    localparam logic [2:0] SEL_GLOBAL = 3'd4;

    typedef struct packed {
        t_cmd             cmd;
        logic [ChW-1:0]   ch;
        logic [2:0]       sel;
        logic [DataW-1:0] data;
    } t_item;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_OUT  = 2'd2
    } t_state;

    typedef struct packed {
        logic [DataW-1:0] rd;
        logic             bad;
        logic             irq;
        logic [3:0]       lvl;
    } t_result;
endpackage

// ===== design/multichannel_pwm_controller_top.sv =====
// Top level of the multichannel PWM controller.
// Each beat passes through the queue and the result register; period writes
// with a nonzero period also pass through the bit-serial counter remainder.
// Throughput: one beat per cycle while results drain; a nonzero period write
// holds the back unit for 32 remainder steps plus write-back.
// Synchronous active-low reset clears all channel registers and done flags.
`timescale 1ns / 1ps
module multichannel_pwm_controller_top import mpwm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // command, channel, register_select, write_data
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // read_data, bad_access, irq, pwm_levels
);
    t_item in_item, q_item;
    logic q_valid, q_ready;
    t_result res;

    assign in_item.cmd  = t_cmd'(s_axis_tdata[1:0]);
    assign in_item.ch   = s_axis_tdata[3:2];
    assign in_item.sel  = s_axis_tdata[6:4];
    assign in_item.data = s_axis_tdata[38:7];

    mpwm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_item(in_item),
        .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item)
    );

    mpwm_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {2'b00, res.lvl, res.irq, res.bad, res.rd};

    a_bad_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[32]) |-> (m_axis_tdata[31:0] == '0))
        else $error("bad access with read data");
    a_no_take_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (u_back.r_state != ST_IDLE) |-> !q_ready)
        else $error("beat taken during modulo");
endmodule

// ===== design/mpwm_front.sv =====
// Input stage and two-entry queue of decoded beats.
`timescale 1ns / 1ps
module mpwm_front import mpwm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_item       i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_item       o_item
);
    t_item r_q [2];
    logic [1:0] r_cnt;
    logic r_rd, r_wr;
    logic push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign push = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign pop = o_valid && i_ready;
    assign o_item = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd <= 1'b0;
            r_wr <= 1'b0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= i_item;
    end
endmodule

// ===== design/mpwm_back.sv =====
// Channel registers, counters, period-write modulo unit and result register.
`timescale 1ns / 1ps
module mpwm_back import mpwm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_item   i_item,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);
    logic [1:0]       r_ctrl [NumChannels];
    logic [DataW-1:0] r_per  [NumChannels];
    logic [DataW-1:0] r_duty [NumChannels];
    logic [DataW-1:0] r_cnt  [NumChannels];
    logic [NumChannels-1:0] r_done;

    t_state r_state, n_state;
    logic [DataW-1:0] r_rem;
    logic [DataW-1:0] r_quo;
    logic [DataW-1:0] r_div;
    logic [5:0]       r_bit;
    logic [ChW-1:0]   r_dch;
    t_result          r_res;
    logic             r_ovalid;

    logic take, out_free, ch_ok, chfit, pdiv;
    logic [DataW:0] trial;
    logic [DataW-1:0] rd;
    logic [NumChannels-1:0] lv, en;

    assign out_free = !r_ovalid || i_ready;
    assign o_ready = (r_state == ST_IDLE) && out_free;
    assign take = i_valid && o_ready;
    assign o_valid = r_ovalid;
    assign o_res = r_res;
    assign chfit = ({30'd0, i_item.ch} < NumChannels);
    assign ch_ok = chfit;
    assign pdiv = (i_item.cmd == CMD_WRITE) && (i_item.sel == SEL_PERIOD)
                  && ch_ok && (i_item.data != '0);

    // restoring remainder: one quotient bit a cycle
    assign trial = {r_rem, r_quo[DataW-1]} - {1'b0, r_div};

    always_comb begin
        for (int c = 0; c < NumChannels; c++) begin
            logic [DataW-1:0] d;
            d = (r_duty[c] < r_per[c]) ? r_duty[c] : r_per[c];
            en[c] = r_ctrl[c][0];
            lv[c] = (r_ctrl[c][0] && r_per[c] != '0)
                  ? ((r_cnt[c] < d) ^ r_ctrl[c][1]) : 1'b0;
        end
    end

    always_comb begin
        rd = '0;
        if (i_item.sel == SEL_GLOBAL)
            rd = {{(DataW-DoneShift-NumChannels){1'b0}}, r_done,
                  {(DoneShift-NumChannels){1'b0}}, en};
        else if (ch_ok) begin
            case (i_item.sel)
                SEL_CTRL:   rd = {30'd0, r_ctrl[i_item.ch]};
                SEL_PERIOD: rd = r_per[i_item.ch];
                SEL_DUTY:   rd = r_duty[i_item.ch];
                SEL_CNT:    rd = r_cnt[i_item.ch];
                default:    rd = '0;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (take && pdiv) n_state = ST_DIV;
            ST_DIV:  if (r_bit == 6'd0) n_state = ST_OUT;
            ST_OUT:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_done <= '0;
            for (int c = 0; c < NumChannels; c++) begin
                r_ctrl[c] <= '0;
                r_per[c] <= '0;
                r_duty[c] <= '0;
                r_cnt[c] <= '0;
            end
        end else begin
            if (r_ovalid && i_ready && !(take && !pdiv)
                && !(r_state == ST_OUT && out_free))
                r_ovalid <= 1'b0;
            if (r_state == ST_DIV) begin
                r_rem <= trial[DataW] ? {r_rem[DataW-2:0], r_quo[DataW-1]}
                                      : trial[DataW-1:0];
                r_quo <= {r_quo[DataW-2:0], 1'b0};
                r_bit <= r_bit - 6'd1;
            end
            if (r_state == ST_OUT && out_free) begin
                r_cnt[r_dch] <= r_rem;
                r_ovalid <= 1'b1;
                r_res.rd <= '0;
                r_res.bad <= 1'b0;
                r_res.irq <= (r_done != '0);
                begin : lvl_div
                    logic [NumChannels-1:0] l2;
                    logic [DataW-1:0] d2;
                    l2 = lv;
                    d2 = (r_duty[r_dch] < r_per[r_dch]) ? r_duty[r_dch] : r_per[r_dch];
                    l2[r_dch] = r_ctrl[r_dch][0] ? ((r_rem < d2) ^ r_ctrl[r_dch][1]) : 1'b0;
                    r_res.lvl <= l2[3:0];
                end
            end
            if (take) begin : step
                logic [1:0]       c2 [NumChannels];
                logic [DataW-1:0] p2 [NumChannels];
                logic [DataW-1:0] d2 [NumChannels];
                logic [DataW-1:0] k2 [NumChannels];
                logic [NumChannels-1:0] dn, l2;
                logic bad, defer;
                logic [DataW-1:0] m;
                bad = 1'b0;
                defer = 1'b0;
                dn = r_done;
                for (int c = 0; c < NumChannels; c++) begin
                    c2[c] = r_ctrl[c]; p2[c] = r_per[c];
                    d2[c] = r_duty[c]; k2[c] = r_cnt[c];
                end
                case (i_item.cmd)
                    CMD_TICK: begin
                        for (int c = 0; c < NumChannels; c++)
                            if (c2[c][0] && p2[c] != '0) begin
                                if ({1'b0, k2[c]} + 33'd1 >= {1'b0, p2[c]}) begin
                                    k2[c] = '0;
                                    dn[c] = 1'b1;
                                end else k2[c] = k2[c] + 32'd1;
                            end
                    end
                    CMD_WRITE: begin
                        if (i_item.sel == SEL_GLOBAL)
                            dn = dn & ~i_item.data[DoneShift +: NumChannels];
                        else if (ch_ok) begin
                            case (i_item.sel)
                                SEL_CTRL: begin
                                    if (!c2[i_item.ch][0] && i_item.data[0])
                                        k2[i_item.ch] = '0;
                                    c2[i_item.ch] = i_item.data[1:0];
                                end
                                SEL_PERIOD: begin
                                    p2[i_item.ch] = i_item.data;
                                    if (i_item.data == '0) k2[i_item.ch] = '0;
                                    else defer = 1'b1;
                                end
                                SEL_DUTY: d2[i_item.ch] = i_item.data;
                                SEL_CNT:  bad = 1'b1;
                                default:  ;
                            endcase
                        end
                    end
                    default: ;
                endcase
                for (int c = 0; c < NumChannels; c++) begin
                    m = (d2[c] < p2[c]) ? d2[c] : p2[c];
                    l2[c] = (c2[c][0] && p2[c] != '0) ? ((k2[c] < m) ^ c2[c][1]) : 1'b0;
                    r_ctrl[c] <= c2[c]; r_per[c] <= p2[c];
                    r_duty[c] <= d2[c]; r_cnt[c] <= k2[c];
                end
                r_done <= dn;
                if (defer) begin
                    r_rem <= '0;
                    r_quo <= r_cnt[i_item.ch];
                    r_div <= i_item.data;
                    r_bit <= 6'(DataW - 1);
                    r_dch <= i_item.ch;
                end else begin
                    r_ovalid <= 1'b1;
                    r_res.rd <= (i_item.cmd == CMD_READ) ? rd : '0;
                    r_res.bad <= bad;
                    r_res.irq <= (dn != '0);
                    r_res.lvl <= l2[3:0];
                end
            end
        end
    end
endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the multichannel PWM controller stream interface.
`timescale 1ns / 1ps
module testbench import mpwm_pkg::*;;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;  // command, channel, register_select, write_data
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;  // read_data, bad_access, irq, pwm_levels

    multichannel_pwm_controller_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    localparam int WatchdogLimit = 20000;
    localparam int RandomItems = 1900;

    typedef struct {
        t_cmd        cmd;
        logic [1:0]  ch;
        logic [2:0]  sel;
        logic [31:0] data;
        logic        known;
        logic [39:0] want;
    } t_row;

    logic [1:0]  ctl_q [NumChannels];
    logic [31:0] per_q [NumChannels];
    logic [31:0] duty_q[NumChannels];
    logic [31:0] cnt_q [NumChannels];
    logic [3:0]  done_q;

    logic [39:0] pending_results[$];
    int errors;
    int beats_in;
    int beats_out;
    int idle_cycles;
    bit sending_done;
    bit hold_off;

    function automatic logic [39:0] pack_item(t_cmd cmd, logic [1:0] ch, logic [2:0] sel,
                                              logic [31:0] data);
        return {1'b0, data, sel, ch, cmd};
    endfunction

    function automatic logic [3:0] channel_levels();
        logic [3:0]  v;
        logic [31:0] d;
        logic        act;
        v = '0;
        for (int c = 0; c < NumChannels; c++) begin
            if (ctl_q[c][0] && per_q[c] != 0) begin
                d = (duty_q[c] < per_q[c]) ? duty_q[c] : per_q[c];
                act = cnt_q[c] < d;
                v[c] = ctl_q[c][1] ? ~act : act;
            end
        end
        return v;
    endfunction

    function automatic logic [39:0] pwm_step(t_cmd cmd, logic [1:0] ch, logic [2:0] sel,
                                             logic [31:0] data);
        logic [31:0] rd;
        logic        bad;
        logic [31:0] glob;
        rd = '0;
        bad = 1'b0;
        glob = '0;
        for (int c = 0; c < NumChannels; c++) glob[c] = ctl_q[c][0];
        glob[DoneShift +: 4] = done_q;
        case (cmd)
            CMD_TICK: begin
                for (int c = 0; c < NumChannels; c++) begin
                    if (ctl_q[c][0] && per_q[c] != 0) begin
                        if ({1'b0, cnt_q[c]} + 33'd1 >= {1'b0, per_q[c]}) begin
                            cnt_q[c] = '0;
                            done_q[c] = 1'b1;
                        end else begin
                            cnt_q[c] = cnt_q[c] + 1;
                        end
                    end
                end
            end
            CMD_READ: begin
                if (sel == SEL_GLOBAL) rd = glob;
                else if (ch < NumChannels) begin
                    case (sel)
                        SEL_CTRL:   rd = {30'd0, ctl_q[ch]};
                        SEL_PERIOD: rd = per_q[ch];
                        SEL_DUTY:   rd = duty_q[ch];
                        SEL_CNT:    rd = cnt_q[ch];
                        default:    rd = '0;
                    endcase
                end
            end
            CMD_WRITE: begin
                if (sel == SEL_GLOBAL) done_q = done_q & ~data[DoneShift +: 4];
                else if (ch < NumChannels) begin
                    case (sel)
                        SEL_CTRL: begin
                            if (!ctl_q[ch][0] && data[0]) cnt_q[ch] = '0;
                            ctl_q[ch] = data[1:0];
                        end
                        SEL_PERIOD: begin
                            per_q[ch] = data;
                            cnt_q[ch] = (data != 0) ? cnt_q[ch] % data : '0;
                        end
                        SEL_DUTY: duty_q[ch] = data;
                        SEL_CNT:  bad = 1'b1;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        return {2'b00, channel_levels(), |done_q, bad, rd};
    endfunction

    t_row rows[$];

    task automatic add_row(t_cmd cmd, logic [1:0] ch, logic [2:0] sel, logic [31:0] data,
                           logic known = 1'b0, logic [39:0] want = '0);
        t_row r;
        r.cmd = cmd; r.ch = ch; r.sel = sel; r.data = data; r.known = known; r.want = want;
        rows.push_back(r);
    endtask

    task automatic send_beat(t_cmd cmd, logic [1:0] ch, logic [2:0] sel, logic [31:0] data,
                             logic known, logic [39:0] want);
        logic [39:0] exp_res;
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        exp_res = pwm_step(cmd, ch, sel, data);
        if (known && exp_res !== want) begin
            $display("%0t predictor disagrees with table: expected %h actual %h",
                     $time, want, exp_res);
            errors++;
        end
        pending_results.push_back(exp_res);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_item(cmd, ch, sel, data);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        beats_in++;
    endtask

    function automatic logic [31:0] rand_period();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        for (int c = 0; c < NumChannels; c++) begin
            ctl_q[c] = '0; per_q[c] = '0; duty_q[c] = '0; cnt_q[c] = '0;
        end
        done_q = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(CMD_READ, 2'd0, SEL_GLOBAL, 32'd0, 1'b1, 40'd0);
        add_row(CMD_READ, 2'd3, SEL_PERIOD, 32'd0, 1'b1, 40'd0);
        add_row(CMD_TICK, 2'd0, SEL_CTRL, 32'd0, 1'b1, 40'd0);
        add_row(CMD_WRITE, 2'd1, SEL_CNT, 32'hFFFF_FFFF, 1'b1, {7'd0, 1'b1, 32'd0});
        add_row(CMD_NONE, 2'd2, SEL_DUTY, 32'hFFFF_FFFF, 1'b1, 40'd0);
        add_row(CMD_WRITE, 2'd0, 3'd7, 32'hFFFF_FFFF, 1'b1, 40'd0);
        add_row(CMD_READ, 2'd0, 3'd5, 32'd0, 1'b1, 40'd0);
        add_row(CMD_WRITE, 2'd0, SEL_PERIOD, 32'd3);
        add_row(CMD_WRITE, 2'd0, SEL_DUTY, 32'hFFFF_FFFF);
        add_row(CMD_WRITE, 2'd0, SEL_CTRL, 32'hFFFF_FFFF);
        add_row(CMD_TICK, 2'd0, SEL_CTRL, 32'd0);
        add_row(CMD_TICK, 2'd0, SEL_CTRL, 32'd0);
        add_row(CMD_TICK, 2'd0, SEL_CTRL, 32'd0);
        add_row(CMD_READ, 2'd0, SEL_GLOBAL, 32'd0);
        add_row(CMD_WRITE, 2'd3, SEL_PERIOD, 32'hFFFF_FFFF);
        add_row(CMD_WRITE, 2'd3, SEL_CTRL, 32'd1);
        add_row(CMD_TICK, 2'd0, SEL_CTRL, 32'd0);
        add_row(CMD_WRITE, 2'd3, SEL_PERIOD, 32'd0);
        add_row(CMD_READ, 2'd3, SEL_CNT, 32'd0);
        add_row(CMD_WRITE, 2'd0, SEL_CTRL, 32'd0);
        add_row(CMD_READ, 2'd0, SEL_CNT, 32'd0);
        add_row(CMD_WRITE, 2'd1, SEL_GLOBAL, 32'hFFFF_FFFF);
        add_row(CMD_READ, 2'd2, SEL_GLOBAL, 32'd0);
        foreach (rows[i])
            send_beat(rows[i].cmd, rows[i].ch, rows[i].sel, rows[i].data,
                      rows[i].known, rows[i].want);

        for (int n = 0; n < RandomItems; n++) begin
            int kind;
            t_cmd cmd;
            logic [1:0] ch;
            logic [2:0] sel;
            logic [31:0] data;
            kind = $urandom_range(0, 99);
            ch = 2'($urandom_range(0, 3));
            data = $urandom;
            if (kind < 45) begin
                cmd = CMD_TICK; sel = 3'($urandom_range(0, 7));
            end else if (kind < 65) begin
                cmd = CMD_READ; sel = 3'($urandom_range(0, 4));
            end else if (kind < 95) begin
                cmd = CMD_WRITE;
                sel = 3'($urandom_range(0, 4));
                if (sel == SEL_PERIOD) data = rand_period();
                else if (sel == SEL_DUTY && $urandom_range(0, 3) != 0)
                    data = $urandom_range(0, 14);
                else if (sel == SEL_CTRL && $urandom_range(0, 1)) data[0] = 1'b1;
            end else begin
                cmd = t_cmd'(2'($urandom_range(0, 3))); sel = 3'($urandom_range(5, 7));
            end
            send_beat(cmd, ch, sel, data, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
        sending_done = 1'b1;
    end

    initial begin
        m_axis_tready = 1'b0;
        hold_off = 1'b0;
        @(posedge i_rst_n);
        forever begin
            int stall;
            if (beats_in > 300 && !hold_off) begin
                hold_off = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_out++;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected beat: expected none actual %h", $time, m_axis_tdata);
                errors++;
            end else begin
                logic [39:0] w;
                w = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== w[31:0]) begin
                    $display("%0t read_data: expected %h actual %h",
                             $time, w[31:0], m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[32] !== w[32]) begin
                    $display("%0t bad_access: expected %b actual %b",
                             $time, w[32], m_axis_tdata[32]);
                    errors++;
                end
                if (m_axis_tdata[33] !== w[33]) begin
                    $display("%0t irq: expected %b actual %b", $time, w[33], m_axis_tdata[33]);
                    errors++;
                end
                if (m_axis_tdata[37:34] !== w[37:34]) begin
                    $display("%0t pwm_levels: expected %h actual %h",
                             $time, w[37:34], m_axis_tdata[37:34]);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("[multichannel_pwm_controller_top] ERROR");
            $finish;
        end
    end

    initial begin
        errors = 0; beats_in = 0; beats_out = 0; idle_cycles = 0; sending_done = 0;
        wait (sending_done);
        wait (pending_results.size() == 0);
        repeat (50) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t leftover: expected %0d more beats actual 0", $time,
                     pending_results.size());
            errors++;
        end
        $display("Sent %0d commands (ticks, register reads and writes), checked %0d results.",
                 beats_in, beats_out);
        if (errors == 0)
            $display("[multichannel_pwm_controller_top] OK");
        else
            $display("[multichannel_pwm_controller_top] ERROR");
        $finish;
    end
endmodule

// ===== filelist.f =====
design/mpwm_pkg.sv
design/mpwm_front.sv
design/mpwm_back.sv
design/multichannel_pwm_controller_top.sv
sim/testbench.sv
